// ----- hdl/bitmap_slot_allocator_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the bitmap slot allocator
// Each macro expands to one labelled concurrent assertion clocked on clk and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BITMAP_SLOT_ALLOCATOR_MACROS_SVH
`define BITMAP_SLOT_ALLOCATOR_MACROS_SVH

// Same-cycle implication.
`define BSA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BSA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/bsa_pkg.sv -----
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared constants, codes and the request token type of the bitmap slot
// allocator.
// ----------------------------------------------------------------------------
package bsa_pkg;

  localparam int SLOTS_PER_WORD  = 32;
  localparam int WORD_W          = 2 * SLOTS_PER_WORD;
  localparam int SLOT_SHIFT      = 8;
  localparam int SLOT_BYTES      = 1 << SLOT_SHIFT;
  localparam int MAX_BLOCK_SLOTS = 32;
  localparam int LIM_W           = 13;
  localparam int NLEV            = 6;

  localparam logic [1:0] MARK_FREE  = 2'b00;
  localparam logic [1:0] MARK_CONT  = 2'b10;
  localparam logic [1:0] MARK_START = 2'b11;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_ROOM = 2'd1;
  localparam logic [1:0] ST_BAD     = 2'd2;

  localparam logic REQ_ALLOC   = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  // One request travelling down the row of word cells.
  typedef struct packed {
    logic       valid;
    logic       req_type;
    logic [2:0] size_log;
    logic [7:0] slot;
    logic       done;
    logic [1:0] status;
    logic [7:0] index;
    logic [5:0] granted;
  } tok_t;

endpackage

// ----- hdl/bsa_cell.sv -----
// ----------------------------------------------------------------------------
// bsa_cell
// One bitmap word of 32 slot marks. Serves the transaction passing through
// it this cycle and hands the token on to the next cell.
// ----------------------------------------------------------------------------
module bsa_cell #(
  parameter int IDX = 0
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  bsa_pkg::tok_t              tok_i,
  input  logic [bsa_pkg::LIM_W-1:0]  limit_i,
  output bsa_pkg::tok_t              tok_o
);
  import bsa_pkg::*;

  localparam int         BASE     = IDX * SLOTS_PER_WORD;
  localparam logic [7:0] BASE_IDX = 8'(BASE);
  localparam logic [7:0] CELL_NUM = 8'(IDX);

  logic [WORD_W-1:0] word_r, word_nxt;
  tok_t              tok_r, tok_nxt;

  logic [31:0]       busy, slot_ok, cont;
  logic [31:0]       fr [NLEV];
  logic [31:0]       cand_lv [NLEV];
  logic [31:0]       cand;
  logic              found;
  logic [4:0]        pick, off;
  logic [WORD_W-1:0] alloc_word;

  logic              match, is_start;
  logic [4:0]        pos;
  logic [31:0]       le_pos, run_x, run_t, clr;
  logic [5:0]        zpos;
  logic [5:0]        freed;
  logic [WORD_W-1:0] rel_word;

  always_comb begin
    for (int k = 0; k < 32; k++) begin
      busy[k]    = |word_r[2*k +: 2];
      cont[k]    = (word_r[2*k +: 2] == MARK_CONT);
      slot_ok[k] = (LIM_W'(BASE + k + 1) <= limit_i);
    end
  end

  // Free-run tree: level L bit j is set when slots j*2^L .. (j+1)*2^L-1 are free.
  always_comb begin
    fr[0] = ~busy;
    for (int l = 1; l < NLEV; l++) begin
      fr[l] = '0;
      for (int j = 0; j < (32 >> l); j++) begin
        fr[l][j] = fr[l-1][2*j] & fr[l-1][2*j+1];
      end
    end
    for (int l = 0; l < NLEV; l++) begin
      cand_lv[l] = '0;
      for (int j = 0; j < (32 >> l); j++) begin
        cand_lv[l][j] = fr[l][j] & slot_ok[((j + 1) << l) - 1];
      end
    end
  end

  always_comb begin
    cand  = (tok_i.size_log <= 3'(NLEV - 1)) ? cand_lv[tok_i.size_log] : '0;
    found = |cand;
    pick  = '0;
    for (int j = 31; j >= 0; j--) begin
      if (cand[j]) begin
        pick = 5'(j);
      end
    end
    off        = pick << tok_i.size_log;
    alloc_word = word_r;
    for (int k = 0; k < 32; k++) begin
      if ((5'(k) >> tok_i.size_log) == pick) begin
        alloc_word[2*k +: 2] = (5'(k) == off) ? MARK_START : MARK_CONT;
      end
    end
  end

  // Release: the continuation run is the trailing ones of the continuation
  // flags once every slot up to the start has been forced to one. A run can
  // never exceed the block size limit inside one word.
  always_comb begin
    match    = ({5'd0, tok_i.slot[7:5]} == CELL_NUM);
    pos      = tok_i.slot[4:0];
    is_start = (word_r[2*pos +: 2] == MARK_START);
    for (int k = 0; k < 32; k++) begin
      le_pos[k] = (5'(k) <= pos);
    end
    run_x    = cont | le_pos;
    run_t    = run_x & ~(run_x + 32'd1);
    clr      = run_t & ~le_pos;
    // The first slot that ends the run gives the count of slots freed.
    zpos     = 6'd32;
    for (int k = 31; k >= 0; k--) begin
      if (!run_x[k]) begin
        zpos = 6'(k);
      end
    end
    freed    = zpos - {1'b0, pos};
    rel_word = word_r;
    for (int k = 0; k < 32; k++) begin
      if (clr[k] || (5'(k) == pos)) begin
        rel_word[2*k +: 2] = MARK_FREE;
      end
    end
  end

  always_comb begin
    word_nxt = word_r;
    tok_nxt  = tok_i;
    if (tok_i.valid && !tok_i.done) begin
      if (tok_i.req_type == REQ_ALLOC) begin
        if (found) begin
          word_nxt        = alloc_word;
          tok_nxt.done    = 1'b1;
          tok_nxt.status  = ST_OK;
          tok_nxt.index   = BASE_IDX + {3'd0, off};
          tok_nxt.granted = 6'd1 << tok_i.size_log;
        end
      end else if (match) begin
        tok_nxt.done = 1'b1;
        if (is_start) begin
          word_nxt        = rel_word;
          tok_nxt.status  = ST_OK;
          tok_nxt.index   = tok_i.slot;
          tok_nxt.granted = freed;
        end else begin
          tok_nxt.status  = ST_BAD;
          tok_nxt.index   = 8'd0;
          tok_nxt.granted = 6'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r      <= '0;
      tok_r.valid <= 1'b0;
    end else begin
      word_r <= word_nxt;
      tok_r  <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule

// ----- hdl/bitmap_slot_allocator.sv -----
// ----------------------------------------------------------------------------
// bitmap_slot_allocator
// Power-of-two aligned slot allocator over a page of 256-byte slots, held as
// a row of bitmap word cells.
// ----------------------------------------------------------------------------
// A request token passes through the row of NWORDS word cells, where
// NWORDS = ceil(MAX_SLOTS / 32) is the number of 64-bit mark words. The
// token visits one word per cycle, each cell checking every aligned
// position of its word at once, and the block holds one transaction at a time.
// The result sits in an output register, so in_ready returns as soon as a
// result has moved there, even if it has not yet been taken. cfg_ready is
// always high; write the page size only while no transaction is in flight.
module bitmap_slot_allocator #(
  parameter int MAX_SLOTS = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_req_type,
  input  logic [15:0] in_byte_count,
  input  logic [7:0] in_release_slot,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_status,
  output logic [7:0] out_slot_index,
  output logic [5:0] out_granted_slots,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [8:0] cfg_slots_in_page
);
  import bsa_pkg::*;

  localparam int               NWORDS  = (MAX_SLOTS + SLOTS_PER_WORD - 1) / SLOTS_PER_WORD;
  localparam logic [LIM_W-1:0] MAX_LIM = LIM_W'(MAX_SLOTS);

  logic [8:0]       sip_r, sip_nxt;
  logic             busy_r, busy_nxt;
  tok_t             tok0_r, tok0_nxt;
  tok_t             fin_r, fin_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_status_r, out_status_nxt;
  logic [7:0]       out_index_r, out_index_nxt;
  logic [5:0]       out_granted_r, out_granted_nxt;

  tok_t             chain [NWORDS+1];
  logic [LIM_W-1:0] limit;
  logic             in_fire, out_load, too_large;
  logic [16:0]      byte_sum;
  logic [8:0]       slots;
  logic [2:0]       size_log;

  assign in_ready  = !busy_r;
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign out_load  = fin_r.valid && (!out_valid_r || out_ready);
  assign limit     = (LIM_W'(sip_r) > MAX_LIM) ? MAX_LIM : LIM_W'(sip_r);

  assign chain[0] = tok0_r;

  for (genvar g = 0; g < NWORDS; g++) begin : g_cell
    bsa_cell #(.IDX(g)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .tok_i   (chain[g]),
      .limit_i (limit),
      .tok_o   (chain[g+1])
    );
  end

  // Round the byte count up to slots, then up to a power of two.
  always_comb begin
    too_large = (in_byte_count > 16'(MAX_BLOCK_SLOTS * SLOT_BYTES));
    byte_sum  = 17'(in_byte_count) + 17'(SLOT_BYTES - 1);
    slots     = 9'(byte_sum >> SLOT_SHIFT);
    priority if (slots <= 9'd1) begin
      size_log = 3'd0;
    end else if (slots <= 9'd2) begin
      size_log = 3'd1;
    end else if (slots <= 9'd4) begin
      size_log = 3'd2;
    end else if (slots <= 9'd8) begin
      size_log = 3'd3;
    end else if (slots <= 9'd16) begin
      size_log = 3'd4;
    end else begin
      size_log = 3'd5;
    end
  end

  always_comb begin
    sip_nxt  = cfg_valid ? cfg_slots_in_page : sip_r;
    busy_nxt = busy_r;
    if (in_fire) begin
      busy_nxt = 1'b1;
    end else if (out_load) begin
      busy_nxt = 1'b0;
    end

    tok0_nxt          = tok0_r;
    tok0_nxt.valid    = in_fire;
    if (in_fire) begin
      tok0_nxt.req_type = in_req_type;
      tok0_nxt.size_log = size_log;
      tok0_nxt.slot     = in_release_slot;
      tok0_nxt.done     = (in_req_type == REQ_ALLOC) && too_large;
      tok0_nxt.status   = ST_BAD;
      tok0_nxt.index    = 8'd0;
      tok0_nxt.granted  = 6'd0;
    end

    // A token that no cell served is a failed request.
    fin_nxt = fin_r;
    if (chain[NWORDS].valid) begin
      fin_nxt = chain[NWORDS];
      if (!chain[NWORDS].done) begin
        fin_nxt.status  = (chain[NWORDS].req_type == REQ_RELEASE) ? ST_BAD : ST_NO_ROOM;
        fin_nxt.index   = 8'd0;
        fin_nxt.granted = 6'd0;
      end
    end else if (out_load) begin
      fin_nxt.valid = 1'b0;
    end

    out_valid_nxt   = out_valid_r && !out_ready;
    out_status_nxt  = out_status_r;
    out_index_nxt   = out_index_r;
    out_granted_nxt = out_granted_r;
    if (out_load) begin
      out_valid_nxt   = 1'b1;
      out_status_nxt  = fin_r.status;
      out_index_nxt   = fin_r.index;
      out_granted_nxt = fin_r.granted;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sip_r        <= 9'd256;
      busy_r       <= 1'b0;
      tok0_r.valid <= 1'b0;
      fin_r.valid  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      sip_r       <= sip_nxt;
      busy_r      <= busy_nxt;
      tok0_r      <= tok0_nxt;
      fin_r       <= fin_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r  <= out_status_nxt;
    out_index_r   <= out_index_nxt;
    out_granted_r <= out_granted_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_slot_index    = out_index_r;
  assign out_granted_slots = out_granted_r;

endmodule

// ----- hdl/bsa_checker.sv -----
// ----------------------------------------------------------------------------
// bsa_checker
// Port-level checks on the bitmap slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "bitmap_slot_allocator_macros.svh"

module bsa_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_status,
  input logic [7:0] out_slot_index,
  input logic [5:0] out_granted_slots
);
  import bsa_pkg::*;

  // A failed transaction reports neither a slot nor a count.
  `BSA_ASSERT_IMP(a_fail_zero, out_valid && (out_status != ST_OK), (out_slot_index == 8'd0) && (out_granted_slots == 6'd0), "failed result carries a slot or count")

  // A successful transaction always grants or frees between one and 32 slots.
  `BSA_ASSERT_IMP(a_ok_count, out_valid && (out_status == ST_OK), (out_granted_slots != 6'd0) && (out_granted_slots <= 6'd32), "successful result with bad slot count")

  // Only one transaction is in flight: acceptance drops ready.
  `BSA_ASSERT_NXT(a_one_in_flight, in_valid && in_ready, !in_ready, "second transaction accepted while busy")

  `BSA_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_slot_index) && $stable(out_granted_slots), "stalled result changed")

endmodule

bind bitmap_slot_allocator bsa_checker u_bsa_checker (.*);

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for bitmap_slot_allocator
// A bit-accurate slot map predicts every grant and release. Directed requests
// cover the size boundaries, zero-byte and oversize allocations, bad releases
// and the page-size corner settings. A long random run follows, mostly
// well-formed allocate and release pairs, with bursty input traffic, output
// back-pressure, one long output hold-off and drains between page-size
// changes.
// ----------------------------------------------------------------------------
module tb_top;
  import bsa_pkg::*;

  localparam int MAX_SLOTS     = 256;
  localparam int NWORDS        = (MAX_SLOTS + SLOTS_PER_WORD - 1) / SLOTS_PER_WORD;
  localparam int LIMIT_CYCLES  = 200000;
  localparam int HOLD_CYCLES   = 100;
  localparam int SETTLE_CYCLES = 16;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 62;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] index;
    logic [5:0] granted;
  } slot_reply_t;

  class slot_scoreboard;
    localparam logic [WORD_W-1:0] START_RUN = 64'hAAAA_AAAA_AAAA_AAAB;

    logic [WORD_W-1:0] marks [NWORDS];
    logic [8:0]        page_slots;
    slot_reply_t       awaited_replies [$];
    int errors, checked, requests;
    int grants, releases, rejects, no_room;

    function new();
      foreach (marks[w]) marks[w] = '0;
      page_slots = 9'd256;
    endfunction

    function void set_page(logic [8:0] v);
      page_slots = v;
    endfunction

    function int pending();
      return awaited_replies.size();
    endfunction

    // Mark pattern of an n-slot run starting at slot 0 of a word.
    function logic [WORD_W-1:0] run_mask(int n);
      if (n >= SLOTS_PER_WORD) return START_RUN;
      return START_RUN & ((64'd1 << (2 * n)) - 64'd1);
    endfunction

    function logic [1:0] mark_of(int s);
      return marks[s / SLOTS_PER_WORD][2 * (s % SLOTS_PER_WORD) +: 2];
    endfunction

    function int used_slots();
      int n;
      n = 0;
      for (int s = 0; s < MAX_SLOTS; s++) if (mark_of(s) != MARK_FREE) n++;
      return n;
    endfunction

    // A random slot carrying the given mark, or -1 if there is none.
    function int pick_slot(logic [1:0] mk);
      int found [$];
      for (int s = 0; s < MAX_SLOTS; s++) if (mark_of(s) == mk) found.push_back(s);
      if (found.size() == 0) return -1;
      return found[$urandom_range(0, found.size() - 1)];
    endfunction

    function slot_reply_t resolve_request(logic rt, logic [15:0] bytes, logic [7:0] rslot);
      slot_reply_t r;
      int slots, size, limit, avail, w, off, p, freed;
      logic [WORD_W-1:0] m;
      r = '{status: ST_BAD, index: 8'd0, granted: 6'd0};
      if (rt == REQ_ALLOC) begin
        if (int'(bytes) > MAX_BLOCK_SLOTS * SLOT_BYTES) return r;
        slots = (int'(bytes) + SLOT_BYTES - 1) / SLOT_BYTES;
        if (slots == 0) slots = 1;
        size = 1;
        while (size < slots && size < MAX_BLOCK_SLOTS) size = size << 1;
        limit = (int'(page_slots) > MAX_SLOTS) ? MAX_SLOTS : int'(page_slots);
        r.status = ST_NO_ROOM;
        for (w = 0; w < NWORDS && w * SLOTS_PER_WORD < limit; w++) begin
          avail = limit - w * SLOTS_PER_WORD;
          if (avail > SLOTS_PER_WORD) avail = SLOTS_PER_WORD;
          for (off = 0; off + size <= avail; off += size) begin
            m = run_mask(size) << (2 * off);
            if ((marks[w] & m) == '0) begin
              marks[w] = marks[w] | m;
              r.status  = ST_OK;
              r.index   = 8'(w * SLOTS_PER_WORD + off);
              r.granted = 6'(size);
              return r;
            end
          end
        end
        return r;
      end
      w = int'(rslot) / SLOTS_PER_WORD;
      p = int'(rslot) % SLOTS_PER_WORD;
      if (w >= NWORDS || marks[w][2 * p +: 2] != MARK_START) return r;
      marks[w][2 * p +: 2] = MARK_FREE;
      freed = 1;
      p++;
      // Continuation marks go up to the next non-continuation, within the word.
      while (p < SLOTS_PER_WORD && freed < MAX_BLOCK_SLOTS &&
             marks[w][2 * p +: 2] == MARK_CONT) begin
        marks[w][2 * p +: 2] = MARK_FREE;
        freed++;
        p++;
      end
      r.status  = ST_OK;
      r.index   = rslot;
      r.granted = 6'(freed);
      return r;
    endfunction

    task note_request(logic rt, logic [15:0] bytes, logic [7:0] rslot);
      slot_reply_t r;
      r = resolve_request(rt, bytes, rslot);
      awaited_replies.push_back(r);
      requests++;
      case (r.status)
        ST_OK:      if (rt == REQ_ALLOC) grants++; else releases++;
        ST_NO_ROOM: no_room++;
        default:    rejects++;
      endcase
    endtask

    task report(string msg);
      if (errors < 40) $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_reply(logic [1:0] st, logic [7:0] idx, logic [5:0] gr);
      slot_reply_t e;
      if (awaited_replies.size() == 0) begin
        report($sformatf("reply with nothing outstanding: status %0d slot %0d count %0d",
                         st, idx, gr));
      end else begin
        e = awaited_replies.pop_front();
        checked++;
        if (st !== e.status)
          report($sformatf("reply %0d status %0d, expected %0d", checked, st, e.status));
        if (idx !== e.index)
          report($sformatf("reply %0d slot %0d, expected %0d", checked, idx, e.index));
        if (gr !== e.granted)
          report($sformatf("reply %0d count %0d, expected %0d", checked, gr, e.granted));
      end
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_req_type;
  logic [15:0] in_byte_count;
  logic [7:0]  in_release_slot;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [7:0]  out_slot_index;
  logic [5:0]  out_granted_slots;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [8:0]  cfg_slots_in_page;

  slot_scoreboard sb;
  int  burst_left;
  int  cycles;
  int  cfg_writes;
  bit  no_idle;
  bit  hold_req;

  bitmap_slot_allocator #(.MAX_SLOTS(MAX_SLOTS)) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_byte_count     (in_byte_count),
    .in_release_slot   (in_release_slot),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_slot_index    (out_slot_index),
    .out_granted_slots (out_granted_slots),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_slots_in_page (cfg_slots_in_page)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT_CYCLES) begin
      $display("Timed out after %0d cycles with %0d replies outstanding.",
               cycles, sb.pending());
      $display("** bitmap_slot_allocator: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_reply(out_status, out_slot_index, out_granted_slots);
  end

  // Output back-pressure: a randomly chosen one of four modes, plus one long
  // hold-off on request from the stimulus.
  initial begin : receiver
    int mode, mode_left, k;
    mode = 0;
    mode_left = 0;
    k = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        k++;
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= ($urandom_range(0, 3) != 0);
          default: out_ready <= ((k % 7) >= 3);
        endcase
      end
    end
  end

  // Called and returns at a falling edge. in_valid stays high after a
  // transaction so that a back-to-back request never lowers and raises it in
  // the same step.
  task automatic send_item(input logic rt, input logic [15:0] bc, input logic [7:0] rs);
    int gap;
    if (burst_left <= 0) begin
      gap = no_idle ? 0 : $urandom_range(1, 14);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_valid        <= 1'b1;
    in_req_type     <= rt;
    in_byte_count   <= bc;
    in_release_slot <= rs;
    do @(posedge clk); while (!in_ready);
    sb.note_request(rt, bc, rs);
    burst_left--;
    @(negedge clk);
  endtask

  task automatic send_alloc(input logic [15:0] bc);
    send_item(REQ_ALLOC, bc, 8'($urandom));
  endtask

  task automatic send_release(input logic [7:0] rs);
    send_item(REQ_RELEASE, 16'($urandom), rs);
  endtask

  task automatic drain_replies();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_page_size(input logic [8:0] v);
    drain_replies();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid         <= 1'b1;
    cfg_slots_in_page <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_page(v);
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly small allocations and releases of live blocks; the rest are larger or
  // oversize allocations and releases of continuation or random slots.
  task automatic random_request();
    int dice, s, alloc_share;
    logic [15:0] b;
    alloc_share = (sb.used_slots() > 160) ? 35 : 60;
    dice = $urandom_range(0, 99);
    case ($urandom_range(0, 19))
      0:       b = 16'($urandom);
      1:       b = 16'(MAX_BLOCK_SLOTS * SLOT_BYTES + $urandom_range(0, 1));
      2, 3, 4: b = 16'($urandom_range(0, MAX_BLOCK_SLOTS * SLOT_BYTES));
      default: b = 16'($urandom_range(0, 8 * SLOT_BYTES));
    endcase
    if (dice < alloc_share) begin
      send_alloc(b);
    end else if (dice < 88) begin
      s = sb.pick_slot(MARK_START);
      if (s < 0) send_alloc(b);
      else send_release(8'(s));
    end else if (dice < 94) begin
      s = sb.pick_slot(MARK_CONT);
      if (s < 0) s = $urandom_range(0, MAX_SLOTS - 1);
      send_release(8'(s));
    end else begin
      send_release(8'($urandom_range(0, MAX_SLOTS - 1)));
    end
  endtask

  initial begin : stimulus
    logic [8:0] page_plan [PHASES];
    int ph, i;
    page_plan = '{9'd256, 9'd64, 9'd37, 9'd511, 9'd1, 9'd200, 9'd0, 9'd256};
    page_plan[6] = 9'($urandom_range(0, 511));
    sb = new();
    burst_left = 0;
    cycles = 0;
    cfg_writes = 0;
    no_idle = 1'b0;
    hold_req = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = REQ_ALLOC;
    in_byte_count = '0;
    in_release_slot = '0;
    cfg_valid = 1'b0;
    cfg_slots_in_page = 9'd256;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Size rounding and boundaries at the reset page size.
    send_alloc(16'd0);
    send_alloc(16'd1);
    send_alloc(16'd256);
    send_alloc(16'd257);
    send_alloc(16'd8192);
    send_alloc(16'd8193);
    send_alloc(16'hFFFF);
    send_alloc(16'd768);
    send_item(REQ_RELEASE, 16'hFFFF, 8'd32);
    send_release(8'd33);
    send_release(8'd5);
    send_release(8'd4);
    send_item(REQ_RELEASE, 16'h0000, 8'd255);
    send_alloc(16'd4096);
    send_alloc(16'd1024);

    // An empty page refuses everything.
    write_page_size(9'd0);
    send_alloc(16'd0);
    send_alloc(16'd8192);
    // A one-slot page: full, then freed, then granted again.
    write_page_size(9'd1);
    send_alloc(16'd0);
    send_release(8'd0);
    send_alloc(16'd200);
    // Partial last word.
    write_page_size(9'd40);
    send_alloc(16'd8192);
    send_alloc(16'd2048);
    // A page size above the slot count is clipped.
    write_page_size(9'd511);
    send_alloc(16'd8192);

    for (ph = 0; ph < PHASES; ph++) begin
      write_page_size(page_plan[ph]);
      no_idle = (ph == 2);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        // Long output hold-off while requests keep coming back to back.
        if (ph == 1 && i == 20) begin
          hold_req = 1'b1;
          no_idle = 1'b1;
        end
        if (ph == 1 && i == 45) no_idle = 1'b0;
        if (ph == 4 && i == 30) drain_replies();
        random_request();
      end
    end

    drain_replies();
    repeat (40) @(negedge clk);
    $display("Ran %0d requests over %0d page-size settings: %0d grants, %0d releases,",
             sb.requests, cfg_writes + 1, sb.grants, sb.releases);
    $display("%0d bad requests, %0d without room; %0d replies checked, %0d mismatches.",
             sb.rejects, sb.no_room, sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("** bitmap_slot_allocator: PASSED **");
    else
      $display("** bitmap_slot_allocator: FAILED **");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/bsa_pkg.sv
hdl/bsa_cell.sv
hdl/bitmap_slot_allocator.sv
hdl/bsa_checker.sv
tb/sv/tb_top.sv
